[hw/rtl/tfd_pkg.sv]
// Shared constants for the range frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package tfd_pkg;

  localparam logic [7:0] SYNC_RANGE   = 8'hA5;
  localparam logic [7:0] SYNC_CONTROL = 8'hA6;

  localparam int RESULT_CAP = 32;
  localparam int CAP_W      = 6;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MIN_VALID = 2'd0;
  localparam cfg_idx_t CFG_MAX_VALID = 2'd1;
  localparam cfg_idx_t CFG_INVALID   = 2'd2;

  localparam logic [15:0] MIN_VALID_RST = 16'd100;
  localparam logic [15:0] MAX_VALID_RST = 16'd4000;
  localparam logic [15:0] INVALID_RST   = 16'd0;

  localparam logic [31:0] SEQ_RST = 32'd1;

endpackage

[hw/rtl/tfd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tof_range_frame_deframer.sv]
// Range frame deframer top level: circular byte buffer, frame scan and zone emit.
// Depends on tfd_pkg and tfd_ram.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i/in_stall_o  | mode_i, byte_in_i, now_ms_i
//  out     | out_valid_o/out_stall_i| sensor_index_o .. last_o
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One transaction at a time; a data byte is written to the buffer, then starts a scan.
// Buffer reads go through the registered RAM port: checksum pass over the frame,
// zone count pass over the zone bytes, two reads per zone to emit. Reset needs no
// clearing pass. Output register lets a new byte enter while the final result waits.
`timescale 1ns / 1ps

module tof_range_frame_deframer #(
  parameter int SENSOR_COUNT        = 2,
  parameter int ZONES_PER_SENSOR    = 16,
  parameter int CONTROL_FRAME_BYTES = 8,
  parameter int BUFFER_BYTES        = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [7:0]            byte_in_i,
  input  logic [31:0]           now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  sensor_index_o,
  output logic [3:0]            zone_index_o,
  output logic [15:0]           range_mm_o,
  output logic                  zone_valid_o,
  output logic [5:0]            valid_zone_count_o,
  output logic [31:0]           frame_sequence_o,
  output logic [31:0]           sensor_uptime_ms_o,
  output logic [31:0]           received_ms_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  tfd_pkg::cfg_idx_t     cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import tfd_pkg::*;

  localparam int ZT          = SENSOR_COUNT * ZONES_PER_SENSOR;
  localparam int RANGE_BYTES = 6 + 2 * ZT;
  localparam int AW          = $clog2(BUFFER_BYTES);
  localparam int CW          = $clog2(BUFFER_BYTES + 1);
  localparam int SUMW        = CW + 1;
  localparam int NMAX        = (RANGE_BYTES > BUFFER_BYTES) ? RANGE_BYTES : BUFFER_BYTES;
  localparam int NW          = $clog2(NMAX + 1);
  localparam int ZW          = $clog2(ZT + 1);
  localparam int SW          = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HEAD  = 3'd1;
  localparam logic [2:0] ST_HEADW = 3'd2;
  localparam logic [2:0] ST_STRM  = 3'd3;
  localparam logic [2:0] ST_ELO   = 3'd4;
  localparam logic [2:0] ST_EHI   = 3'd5;
  localparam logic [2:0] ST_EOUT  = 3'd6;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SUMW-1:0] s;
    s = SUMW'(base) + SUMW'(off);
    if (s >= SUMW'(BUFFER_BYTES)) begin
      s = s - SUMW'(BUFFER_BYTES);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            have_up_q, have_up_d;
  logic [31:0]     last_up_q, last_up_d;
  logic [31:0]     next_seq_q, next_seq_d;
  logic [15:0]     min_q, max_q, inv_q;
  logic [31:0]     recv_q, recv_d;
  logic            is_rng_q, is_rng_d;
  logic [NW-1:0]   need_q, need_d;
  logic            pass_cnt_q, pass_cnt_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic [CW-1:0]   end_q, end_d;
  logic            rv_q, rv_d;
  logic [CW-1:0]   roff_q, roff_d;
  logic [7:0]      acc_q, acc_d;
  logic [31:0]     up_q, up_d;
  logic [31:0]     seq_q, seq_d;
  logic            ph_q, ph_d;
  logic [7:0]      lo_q, lo_d;
  logic [ZW-1:0]   cnt_q, cnt_d;
  logic [CAP_W-1:0] step_q, step_d;
  logic [3:0]      zone_q, zone_d;
  logic [SW-1:0]   sens_q, sens_d;
  logic [CW-1:0]   zoff_q, zoff_d;

  logic            out_valid_q;
  logic            out_load;
  logic            sens_ix_q;
  logic [3:0]      zone_ix_q;
  logic [15:0]     range_q;
  logic            zvalid_q;
  logic [5:0]      vcount_q;
  logic [31:0]     oseq_q, oup_q, orecv_q;
  logic            last_q;

  logic            we;
  logic [AW-1:0]   waddr;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;

  logic [15:0]     mm_cnt, mm_emit;
  logic            ok_cnt, ok_emit;
  logic            last_zone;
  logic [31:0]     delta;
  logic            accept;

  tfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_in_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign mm_cnt    = {rdata, lo_q};
  assign ok_cnt    = (mm_cnt >= min_q) && (mm_cnt <= max_q);
  assign mm_emit   = {rdata, lo_q};
  assign ok_emit   = (mm_emit >= min_q) && (mm_emit <= max_q);
  assign last_zone = (sens_q == SW'(SENSOR_COUNT - 1)) && (zone_q == 4'(ZONES_PER_SENSOR - 1));
  assign delta     = up_q - last_up_q;
  assign out_load  = (state_q == ST_EOUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fill_d     = fill_q;
    have_up_d  = have_up_q;
    last_up_d  = last_up_q;
    next_seq_d = next_seq_q;
    recv_d     = recv_q;
    is_rng_d   = is_rng_q;
    need_d     = need_q;
    pass_cnt_d = pass_cnt_q;
    iss_d      = iss_q;
    end_d      = end_q;
    rv_d       = 1'b0;
    roff_d     = roff_q;
    acc_d      = acc_q;
    up_d       = up_q;
    seq_d      = seq_q;
    ph_d       = ph_q;
    lo_d       = lo_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    zone_d     = zone_q;
    sens_d     = sens_q;
    zoff_d     = zoff_q;
    we         = 1'b0;
    waddr      = wrap_add(head_q, fill_q);
    re         = 1'b0;
    raddr      = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d = '0;
          recv_d = now_ms_i;
          if (mode_i) begin
            fill_d    = '0;
            have_up_d = 1'b0;
          end else begin
            we      = 1'b1;
            state_d = ST_HEAD;
            if (fill_q == CW'(BUFFER_BYTES)) begin
              waddr  = head_q;
              head_d = wrap_add(head_q, CW'(1));
            end else begin
              fill_d = fill_q + CW'(1);
            end
          end
        end
      end
      ST_HEAD: begin
        if (fill_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          re      = 1'b1;
          state_d = ST_HEADW;
        end
      end
      ST_HEADW: begin
        if (rdata != SYNC_RANGE && rdata != SYNC_CONTROL) begin
          head_d  = wrap_add(head_q, CW'(1));
          fill_d  = fill_q - CW'(1);
          state_d = ST_HEAD;
        end else begin
          is_rng_d = (rdata == SYNC_RANGE);
          need_d   = (rdata == SYNC_RANGE) ? NW'(RANGE_BYTES) : NW'(CONTROL_FRAME_BYTES);
          if (NW'(fill_q) < need_d) begin
            state_d = ST_IDLE;
          end else begin
            pass_cnt_d = 1'b0;
            iss_d      = '0;
            end_d      = CW'(need_d - NW'(1));
            acc_d      = '0;
            state_d    = ST_STRM;
          end
        end
      end
      ST_STRM: begin
        if (iss_q <= end_q) begin
          re     = 1'b1;
          raddr  = wrap_add(head_q, iss_q);
          rv_d   = 1'b1;
          roff_d = iss_q;
          iss_d  = iss_q + CW'(1);
        end
        if (rv_q) begin
          if (!pass_cnt_q) begin
            if (roff_q >= CW'(1) && roff_q <= CW'(4)) begin
              up_d = {rdata, up_q[31:8]};
            end
            if (roff_q != end_q) begin
              acc_d = acc_q ^ rdata;
            end else begin
              rv_d = 1'b0;
              if (acc_q != rdata) begin
                head_d  = wrap_add(head_q, CW'(1));
                fill_d  = fill_q - CW'(1);
                state_d = ST_HEAD;
              end else if (!is_rng_q ||
                           (have_up_q && (delta == '0 || delta[31]))) begin
                head_d  = wrap_add(head_q, CW'(need_q));
                fill_d  = fill_q - CW'(need_q);
                state_d = ST_HEAD;
              end else begin
                seq_d      = next_seq_q;
                next_seq_d = next_seq_q + 32'd1;
                pass_cnt_d = 1'b1;
                iss_d      = CW'(5);
                end_d      = CW'(need_q - NW'(2));
                ph_d       = 1'b0;
                cnt_d      = '0;
              end
            end
          end else begin
            ph_d = !ph_q;
            if (!ph_q) begin
              lo_d = rdata;
            end else if (ok_cnt) begin
              cnt_d = cnt_q + ZW'(1);
            end
            if (roff_q == end_q) begin
              rv_d = 1'b0;
              if (cnt_d == '0) begin
                head_d  = wrap_add(head_q, CW'(need_q));
                fill_d  = fill_q - CW'(need_q);
                state_d = ST_HEAD;
              end else begin
                last_up_d = up_q;
                have_up_d = 1'b1;
                zone_d    = '0;
                sens_d    = '0;
                zoff_d    = CW'(5);
                state_d   = ST_ELO;
              end
            end
          end
        end
      end
      ST_ELO: begin
        if (step_q == CAP_W'(RESULT_CAP)) begin
          head_d  = wrap_add(head_q, CW'(need_q));
          fill_d  = fill_q - CW'(need_q);
          state_d = ST_HEAD;
        end else begin
          re      = 1'b1;
          raddr   = wrap_add(head_q, zoff_q);
          state_d = ST_EHI;
        end
      end
      ST_EHI: begin
        lo_d    = rdata;
        re      = 1'b1;
        raddr   = wrap_add(head_q, zoff_q + CW'(1));
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        if (out_load) begin
          step_d = step_q + CAP_W'(1);
          zoff_d = zoff_q + CW'(2);
          if (last_zone) begin
            head_d  = wrap_add(head_q, CW'(need_q));
            fill_d  = fill_q - CW'(need_q);
            state_d = ST_HEAD;
          end else begin
            if (zone_q == 4'(ZONES_PER_SENSOR - 1)) begin
              zone_d = '0;
              sens_d = sens_q + SW'(1);
            end else begin
              zone_d = zone_q + 4'd1;
            end
            state_d = ST_ELO;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      fill_q     <= '0;
      have_up_q  <= 1'b0;
      last_up_q  <= '0;
      next_seq_q <= SEQ_RST;
      rv_q       <= 1'b0;
      step_q     <= '0;
      out_valid_q <= 1'b0;
      min_q      <= MIN_VALID_RST;
      max_q      <= MAX_VALID_RST;
      inv_q      <= INVALID_RST;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      fill_q     <= fill_d;
      have_up_q  <= have_up_d;
      last_up_q  <= last_up_d;
      next_seq_q <= next_seq_d;
      rv_q       <= rv_d;
      step_q     <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MIN_VALID: min_q <= cfg_data_i;
          CFG_MAX_VALID: max_q <= cfg_data_i;
          CFG_INVALID:   inv_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    recv_q     <= recv_d;
    is_rng_q   <= is_rng_d;
    need_q     <= need_d;
    pass_cnt_q <= pass_cnt_d;
    iss_q      <= iss_d;
    end_q      <= end_d;
    roff_q     <= roff_d;
    acc_q      <= acc_d;
    up_q       <= up_d;
    seq_q      <= seq_d;
    ph_q       <= ph_d;
    lo_q       <= lo_d;
    cnt_q      <= cnt_d;
    zone_q     <= zone_d;
    sens_q     <= sens_d;
    zoff_q     <= zoff_d;
    if (out_load) begin
      sens_ix_q <= sens_q[0];
      zone_ix_q <= zone_q;
      range_q   <= ok_emit ? mm_emit : inv_q;
      zvalid_q  <= ok_emit;
      vcount_q  <= cnt_q[5:0];
      oseq_q    <= seq_q;
      oup_q     <= up_q;
      orecv_q   <= recv_q;
      last_q    <= last_zone;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sensor_index_o     = sens_ix_q;
  assign zone_index_o       = zone_ix_q;
  assign range_mm_o         = range_q;
  assign zone_valid_o       = zvalid_q;
  assign valid_zone_count_o = vcount_q;
  assign frame_sequence_o   = oseq_q;
  assign sensor_uptime_ms_o = oup_q;
  assign received_ms_o      = orecv_q;
  assign last_o             = last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(BUFFER_BYTES))
    else $error("buffer fill beyond depth");

  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= CAP_W'(RESULT_CAP))
    else $error("too many results in one transaction");

  a_rv_strm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> state_q == ST_STRM)
    else $error("read data pending outside stream pass");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EOUT)
    else $error("result without emit");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for tof_range_frame_deframer: directed byte table,
// then random range/control frames, noise and buffer resets, checked by a zone predictor.
// Depends on tfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;
  import tfd_pkg::*;

  localparam int ZONE_TOTAL = 32;
  localparam int RANGE_LEN  = 5 + 2 * ZONE_TOTAL + 1;
  localparam int CTRL_LEN   = 8;
  localparam int BUF_DEPTH  = 128;
  localparam int SETTLE     = 400;
  localparam int LIMIT      = 1500000;

  typedef struct packed {
    logic        sensor;
    logic [3:0]  zone;
    logic [15:0] dist_mm;
    logic        ok;
    logic [5:0]  n_valid;
    logic [31:0] seq;
    logic [31:0] uptime;
    logic [31:0] rx_ms;
    logic        last;
  } zone_result_t;

  typedef struct {
    logic        mode;
    logic [7:0]  data;
    logic [31:0] now;
    int          n_zones;
  } byte_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic [7:0] byte_in_i = 8'h00;
  logic [31:0] now_ms_i = 32'h0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic sensor_index_o;
  logic [3:0] zone_index_o;
  logic [15:0] range_mm_o;
  logic zone_valid_o;
  logic [5:0] valid_zone_count_o;
  logic [31:0] frame_sequence_o;
  logic [31:0] sensor_uptime_ms_o;
  logic [31:0] received_ms_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_idx_t cfg_index_i = CFG_MIN_VALID;
  logic [15:0] cfg_data_i = 16'h0;

  tof_range_frame_deframer uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  rx_bytes[$];
  logic        uptime_seen;
  logic [31:0] last_uptime;
  logic [31:0] next_seq;
  logic [15:0] min_mm, max_mm, bad_code;
  zone_result_t zones_pending[$];

  int errors = 0;
  int items = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  logic [31:0] now_ctr = 32'd0;
  logic [31:0] uptime_ctr = 32'd1000;

  function automatic bit zone_ok(logic [15:0] mm);
    return mm >= min_mm && mm <= max_mm;
  endfunction

  function automatic void take_range_frame(logic [31:0] now);
    logic [31:0] up;
    logic [31:0] seq;
    logic [15:0] mm;
    int n;
    zone_result_t r;
    up = {rx_bytes[4], rx_bytes[3], rx_bytes[2], rx_bytes[1]};
    n = 0;
    if (uptime_seen && (up - last_uptime == 0 || up - last_uptime > 32'h7FFF_FFFF)) return;
    seq = next_seq;
    next_seq = next_seq + 32'd1;
    for (int z = 0; z < ZONE_TOTAL; z++) begin
      mm = {rx_bytes[6 + 2 * z], rx_bytes[5 + 2 * z]};
      if (zone_ok(mm)) n++;
    end
    if (n == 0) return;
    last_uptime = up;
    uptime_seen = 1'b1;
    for (int z = 0; z < ZONE_TOTAL; z++) begin
      mm = {rx_bytes[6 + 2 * z], rx_bytes[5 + 2 * z]};
      r.sensor   = 1'(z / 16);
      r.zone     = 4'(z % 16);
      r.ok       = zone_ok(mm);
      r.dist_mm  = r.ok ? mm : bad_code;
      r.n_valid  = 6'(n);
      r.seq      = seq;
      r.uptime   = up;
      r.rx_ms    = now;
      r.last     = (z == ZONE_TOTAL - 1);
      zones_pending.push_back(r);
    end
  endfunction

  function automatic void predict_zones(logic mode, logic [7:0] data, logic [31:0] now);
    int need;
    logic [7:0] x;
    if (mode) begin
      rx_bytes.delete();
      uptime_seen = 1'b0;
      return;
    end
    if (rx_bytes.size() >= BUF_DEPTH) void'(rx_bytes.pop_front());
    rx_bytes.push_back(data);
    while (rx_bytes.size() > 0) begin
      if (rx_bytes[0] != SYNC_RANGE && rx_bytes[0] != SYNC_CONTROL) begin
        void'(rx_bytes.pop_front());
        continue;
      end
      need = (rx_bytes[0] == SYNC_RANGE) ? RANGE_LEN : CTRL_LEN;
      if (rx_bytes.size() < need) break;
      x = 8'h00;
      for (int i = 0; i < need - 1; i++) x ^= rx_bytes[i];
      if (x != rx_bytes[need - 1]) begin
        void'(rx_bytes.pop_front());
        continue;
      end
      if (rx_bytes[0] == SYNC_RANGE) take_range_frame(now);
      for (int i = 0; i < need; i++) void'(rx_bytes.pop_front());
    end
  endfunction

  task automatic send_byte(logic mode, logic [7:0] data, logic [31:0] now);
    int gap;
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    byte_in_i  <= data;
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_stall_o);
    predict_zones(mode, data, now);
    items++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic tick_now();
    if ($urandom_range(0, 30) == 0) now_ctr = $urandom();
    else now_ctr = now_ctr + $urandom_range(0, 40);
  endtask

  task automatic send_frame(int kind, logic [31:0] up);
    logic [7:0] fb[RANGE_LEN];
    logic [7:0] x;
    logic [15:0] mm;
    int len;
    len = (kind == 2) ? CTRL_LEN : RANGE_LEN;
    fb[0] = (kind == 2) ? SYNC_CONTROL : SYNC_RANGE;
    if (kind == 2) begin
      for (int i = 1; i < CTRL_LEN - 1; i++) fb[i] = 8'($urandom());
    end else begin
      {fb[4], fb[3], fb[2], fb[1]} = up;
      for (int z = 0; z < ZONE_TOTAL; z++) begin
        case ($urandom_range(0, 7))
          0: mm = 16'h0000;
          1: mm = 16'hFFFF;
          2: mm = min_mm;
          3: mm = max_mm;
          4: mm = min_mm - 16'd1;
          5: mm = max_mm + 16'd1;
          default: mm = 16'($urandom_range(0, 5000));
        endcase
        if (kind == 3) mm = (max_mm != 16'hFFFF) ? max_mm + 16'd1 : min_mm - 16'd1;
        {fb[6 + 2 * z], fb[5 + 2 * z]} = mm;
      end
    end
    x = 8'h00;
    for (int i = 0; i < len - 1; i++) x ^= fb[i];
    fb[len - 1] = (kind == 1) ? x ^ (8'h01 << $urandom_range(0, 7)) : x;
    if (kind == 4) len = $urandom_range(2, RANGE_LEN - 2);
    for (int i = 0; i < len; i++) begin
      tick_now();
      send_byte(1'b0, fb[i], now_ctr);
    end
    frames_sent++;
  endtask

  function automatic logic [31:0] next_uptime();
    case ($urandom_range(0, 11))
      0: return uptime_ctr;
      1: return uptime_ctr - $urandom_range(1, 100);
      2: return uptime_ctr + 32'h7FFF_FFFF;
      3: return uptime_ctr + 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      5: return 32'h0000_0000;
      default: return uptime_ctr + $urandom_range(1, 200);
    endcase
  endfunction

  task automatic drain();
    while (zones_pending.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MIN_VALID: min_mm = data;
      CFG_MAX_VALID: max_mm = data;
      CFG_INVALID:   bad_code = data;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: random stall bursts and checking
  always @(posedge clk_i) begin
    zone_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (zones_pending.size() == 0) begin
        $display("%0t: unexpected result zone %0d seq %0d", $time, zone_index_o,
                 frame_sequence_o);
        errors++;
      end else begin
        want = zones_pending.pop_front();
        check_field("sensor_index", 32'(want.sensor), 32'(sensor_index_o));
        check_field("zone_index", 32'(want.zone), 32'(zone_index_o));
        check_field("range", 32'(want.dist_mm), 32'(range_mm_o));
        check_field("zone_valid", 32'(want.ok), 32'(zone_valid_o));
        check_field("zone count", 32'(want.n_valid), 32'(valid_zone_count_o));
        check_field("frame_sequence", want.seq, frame_sequence_o);
        check_field("uptime", want.uptime, sensor_uptime_ms_o);
        check_field("received_ms", want.rx_ms, received_ms_o);
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, zones_pending.size());
      $display("** tof_range_frame_deframer: FAILED **");
      $finish;
    end
  end

  byte_row_t dir_rows[] = '{
    '{1'b1, 8'hA5, 32'h0000_0000, 0},
    '{1'b0, 8'h00, 32'h0000_0000, 0},
    '{1'b0, 8'hFF, 32'hFFFF_FFFF, 0},
    '{1'b0, 8'h5A, 32'h1234_5678, 0},
    '{1'b0, 8'hA6, 32'h0000_0010, 0},
    '{1'b0, 8'h01, 32'h0000_0011, 0},
    '{1'b0, 8'h02, 32'h0000_0012, 0},
    '{1'b0, 8'h03, 32'h0000_0013, 0},
    '{1'b0, 8'h04, 32'h0000_0014, 0},
    '{1'b0, 8'h05, 32'h0000_0015, 0},
    '{1'b0, 8'h06, 32'h0000_0016, 0},
    '{1'b0, 8'hA1, 32'h0000_0017, 0},
    '{1'b0, 8'hA6, 32'h0000_0020, 0},
    '{1'b0, 8'hA5, 32'h0000_0021, 0},
    '{1'b0, 8'h00, 32'h0000_0022, 0},
    '{1'b0, 8'h00, 32'h0000_0023, 0},
    '{1'b0, 8'h00, 32'h0000_0024, 0},
    '{1'b0, 8'h00, 32'h0000_0025, 0},
    '{1'b0, 8'h00, 32'h0000_0026, 0},
    '{1'b0, 8'hFF, 32'h0000_0027, 0},
    '{1'b1, 8'h00, 32'hFFFF_FFFF, 0}
  };

  logic [15:0] phase_cfg[5][3] = '{
    '{16'd100, 16'd4000, 16'h0000},
    '{16'd0, 16'hFFFF, 16'hFFFF},
    '{16'd1000, 16'd1000, 16'h5A5A},
    '{16'd3000, 16'd200, 16'h1234},
    '{16'd50, 16'd2500, 16'h8001}
  };

  initial begin
    int before_n;
    int phase_items;
    int pick;
    logic [31:0] up;
    rx_bytes.delete();
    uptime_seen = 1'b0;
    last_uptime = 32'h0;
    next_seq    = SEQ_RST;
    min_mm      = MIN_VALID_RST;
    max_mm      = MAX_VALID_RST;
    bad_code    = INVALID_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      before_n = zones_pending.size();
      send_byte(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].now);
      if (zones_pending.size() - before_n != dir_rows[i].n_zones) begin
        $display("%0t: row %0d expected %0d zone results, predicted %0d", $time, i,
                 dir_rows[i].n_zones, zones_pending.size() - before_n);
        errors++;
      end
    end

    for (int p = 0; p < 5; p++) begin
      in_valid_i <= 1'b0;
      drain();
      if (p == 4) quiet = 1'b1;
      write_reg(CFG_MIN_VALID, phase_cfg[p][0]);
      write_reg(CFG_MAX_VALID, phase_cfg[p][1]);
      write_reg(CFG_INVALID, (p == 4) ? 16'($urandom()) : phase_cfg[p][2]);
      phase_items = items;
      while (items - phase_items < 50) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          up = next_uptime();
          send_frame(0, up);
          if (up - uptime_ctr < 32'h8000_0000) uptime_ctr = up;
        end else if (pick < 13) begin
          send_frame(1, uptime_ctr + 5);
        end else if (pick < 14) begin
          uptime_ctr = uptime_ctr + 7;
          send_frame(3, uptime_ctr);
        end else if (pick < 15) begin
          send_frame(4, uptime_ctr + 9);
        end else if (pick < 17) begin
          send_frame(2, 0);
        end else if (pick < 19) begin
          repeat ($urandom_range(1, 5)) begin
            tick_now();
            send_byte(1'b0, $urandom_range(0, 9) == 0 ? SYNC_CONTROL : 8'($urandom()),
                      now_ctr);
          end
        end else begin
          send_byte(1'b1, 8'($urandom()), now_ctr);
        end
        if (p == 1 && items - phase_items > 25 && zones_pending.size() > 0) begin
          in_valid_i <= 1'b0;
          while (zones_pending.size() > 0) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    drain();
    $display("Sent %0d input transactions (%0d frames) over 5 register settings,", items,
             frames_sent);
    $display("checked %0d zone results.", results_seen);
    if (errors == 0 && zones_pending.size() == 0) begin
      $display("** tof_range_frame_deframer: PASSED **");
    end else begin
      $display("** tof_range_frame_deframer: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_ram.sv
hw/rtl/tof_range_frame_deframer.sv
verif/tb_top.sv
